/* sv/rbap_pkg.sv */
package rbap_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_e;

  // Configuration register word indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_AUDIO_SIZE = 2'd0,
    REG_PAUSE_THR  = 2'd1,
    REG_RESUME_THR = 2'd2
  } reg_idx_e;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [31:0] AUDIO_SIZE_RST = 32'd0;
  localparam logic [15:0] PAUSE_THR_RST  = 16'd384;
  localparam logic [15:0] RESUME_THR_RST = 16'd128;

  // Input transaction payload
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] sample_byte;
  } req_t;

  // Result transaction payload
  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       output_enabled;
    logic       halt_receive;
    logic       is_stopped;
  } rsp_t;

endpackage

/* sv/rbap_req_if.sv */
interface rbap_req_if;
  logic               valid;
  logic               ready;
  rbap_pkg::req_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/rbap_rsp_if.sv */
interface rbap_rsp_if;
  logic               valid;
  logic               ready;
  rbap_pkg::rsp_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/ring_buffer_audio_player_unit.sv */
// Channel   Dir  Handshake         Payload
// req_i     in   valid/ready       req_type, sample_byte
// rsp_o     out  valid/ready       pwm_duty, output_enabled, halt_receive, is_stopped
// APB       in   psel/penable      audio_size, pause_threshold, resume_threshold
//
// One transaction per cycle unless rsp_o stalls; each request produces its result in the
// cycle after acceptance, held in a single output register.
// The sample store is read every cycle at the next play position, so a tick
// always sees a registered byte; a bypass covers a write to that position.
// A fill mark makes never-written store entries read as zero; no clearing pass.
// rst_ni clears all control state; a reset request clears playback only.
// req_i.ready is high whenever the output register is empty or being drained.
module ring_buffer_audio_player_unit #(
  parameter int unsigned BUFFER_DEPTH = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rbap_req_if.sink                      req_i,
  rbap_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbap_pkg::PADDR_W-1:0]  paddr,
  input  logic [rbap_pkg::PDATA_W-1:0]  pwdata,
  output logic [rbap_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned FW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(BUFFER_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(BUFFER_DEPTH);

  // Configuration registers
  logic [31:0] audio_size_q;
  logic [15:0] pause_thr_q;
  logic [15:0] resume_thr_q;

  // Playback state
  logic [31:0]   rc_q, rc_d;
  logic [31:0]   pc_q, pc_d;
  logic [AW-1:0] rc_idx_q, rc_idx_d;
  logic [AW-1:0] pc_idx_q, pc_idx_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          halt_q, halt_d;
  logic          stopped_q, stopped_d;
  logic [7:0]    duty_q, duty_d;
  logic          drive_q, drive_d;

  // Store and its read path
  logic [7:0]    mem [BUFFER_DEPTH];
  logic [7:0]    rd_q;
  logic          rd_valid_q;
  logic          byp_hit_q;
  logic [7:0]    byp_byte_q;
  logic [7:0]    cur_byte;
  logic          wr_en;

  // Output register
  logic           out_valid_q;
  rbap_pkg::rsp_t out_q;

  logic          in_accept;
  logic          cfg_wr;
  logic [31:0]   pc_inc;
  logic [32:0]   resume_sum;
  logic [32:0]   pause_sum;

  assign in_accept = req_i.valid && req_i.ready;
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_size_q <= rbap_pkg::AUDIO_SIZE_RST;
      pause_thr_q  <= rbap_pkg::PAUSE_THR_RST;
      resume_thr_q <= rbap_pkg::RESUME_THR_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rbap_pkg::REG_AUDIO_SIZE: audio_size_q <= pwdata;
        rbap_pkg::REG_PAUSE_THR:  pause_thr_q  <= pwdata[15:0];
        rbap_pkg::REG_RESUME_THR: resume_thr_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        rbap_pkg::REG_AUDIO_SIZE: prdata = audio_size_q;
        rbap_pkg::REG_PAUSE_THR:  prdata = {16'd0, pause_thr_q};
        rbap_pkg::REG_RESUME_THR: prdata = {16'd0, resume_thr_q};
        default:                  prdata = '0;
      endcase
    end
  end

  // Byte at the current play position: same-cycle write, then fill mark
  assign cur_byte = byp_hit_q ? byp_byte_q : (rd_valid_q ? rd_q : 8'd0);

  assign pc_inc     = pc_q + 32'd1;
  assign resume_sum = {1'b0, pc_inc} + {17'd0, resume_thr_q};
  assign pause_sum  = {1'b0, pc_inc} + {17'd0, pause_thr_q};

  // Next-state logic for one request
  always_comb begin
    rc_d      = rc_q;
    pc_d      = pc_q;
    rc_idx_d  = rc_idx_q;
    pc_idx_d  = pc_idx_q;
    fill_d    = fill_q;
    halt_d    = halt_q;
    stopped_d = stopped_q;
    duty_d    = duty_q;
    drive_d   = drive_q;
    wr_en     = 1'b0;
    if (in_accept) begin
      case (req_i.data.req_type)
        rbap_pkg::REQ_TICK: begin
          if (rc_q != 32'd0) begin
            if (stopped_q) begin
              stopped_d = 1'b0;
              drive_d   = 1'b1;
            end else begin
              if (pc_q >= audio_size_q) begin
                drive_d   = 1'b0;
                stopped_d = 1'b1;
              end
              duty_d = cur_byte;
              pc_d   = pc_inc;
              // index follows count mod depth, including the 2^32 wrap
              if (pc_q == 32'hFFFF_FFFF || pc_idx_q == IDX_LAST) begin
                pc_idx_d = '0;
              end else begin
                pc_idx_d = pc_idx_q + AW'(1);
              end
              if (halt_q) begin
                if ({1'b0, rc_q} < resume_sum) halt_d = 1'b0;
              end else begin
                if ({1'b0, rc_q} >= pause_sum) halt_d = 1'b1;
              end
            end
          end
        end
        rbap_pkg::REQ_WRITE: begin
          wr_en = 1'b1;
          rc_d  = rc_q + 32'd1;
          if (rc_q == 32'hFFFF_FFFF || rc_idx_q == IDX_LAST) begin
            rc_idx_d = '0;
          end else begin
            rc_idx_d = rc_idx_q + AW'(1);
          end
          // writes always land at or below the fill mark
          if (FW'(rc_idx_q) == fill_q && fill_q < FILL_MAX) begin
            fill_d = fill_q + FW'(1);
          end
        end
        rbap_pkg::REQ_CLEAR: begin
          rc_d      = '0;
          pc_d      = '0;
          rc_idx_d  = '0;
          pc_idx_d  = '0;
          halt_d    = 1'b0;
          stopped_d = 1'b1;
          duty_d    = 8'd0;
          drive_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q        <= '0;
      pc_q        <= '0;
      rc_idx_q    <= '0;
      pc_idx_q    <= '0;
      fill_q      <= '0;
      halt_q      <= 1'b0;
      stopped_q   <= 1'b1;
      duty_q      <= 8'd0;
      drive_q     <= 1'b0;
      rd_valid_q  <= 1'b0;
      byp_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rc_q        <= rc_d;
      pc_q        <= pc_d;
      rc_idx_q    <= rc_idx_d;
      pc_idx_q    <= pc_idx_d;
      fill_q      <= fill_d;
      halt_q      <= halt_d;
      stopped_q   <= stopped_d;
      duty_q      <= duty_d;
      drive_q     <= drive_d;
      rd_valid_q  <= FW'(pc_idx_d) < fill_d;
      byp_hit_q   <= wr_en && (rc_idx_q == pc_idx_d);
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sample store: one write port, one registered read at the next play position
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[rc_idx_q] <= req_i.data.sample_byte;
    end
    rd_q       <= mem[pc_idx_d];
    byp_byte_q <= req_i.data.sample_byte;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q.pwm_duty       <= duty_d;
      out_q.output_enabled <= drive_d;
      out_q.halt_receive   <= halt_d;
      out_q.is_stopped     <= stopped_d;
    end
  end

  // Output drive and stopped state are always complementary
  a_drive_vs_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q != stopped_q)
    else $error("drive enable and stopped flag disagree");

  // Fill mark never passes the store depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("fill mark beyond store depth");

  // A reset request shows up as a stopped, silent result
  a_clear_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && req_i.data.req_type == rbap_pkg::REQ_CLEAR) |=>
      (out_valid_q && out_q.is_stopped && !out_q.output_enabled &&
       !out_q.halt_receive && out_q.pwm_duty == 8'd0))
    else $error("reset request result not cleared");

  // Every accepted request leaves a result in the output register
  a_accept_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted request produced no result");

  // A reset request clears both indexes and the played count
  a_idx_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && req_i.data.req_type == rbap_pkg::REQ_CLEAR) |=>
      (pc_idx_q == '0 && rc_idx_q == '0 && pc_q == 32'd0))
    else $error("indexes not cleared with counts");

endmodule
